// ----- design/tts_pkg.sv -----
// Shared types for the thread table round-robin scheduler.
// No dependencies; tts_table and the scheduler unit import this package.
package tts_pkg;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_EXIT   = 2'd1,
    OP_JOIN   = 2'd2,
    OP_YIELD  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    SLOT_DEAD     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2,
    SLOT_BLOCKED  = 2'd3
  } slot_state_t;

  // One entry of the thread table.
  typedef struct packed {
    slot_state_t st;
    logic [3:0]  join_target;
  } entry_t;

endpackage

// ----- design/tts_if.sv -----
// Valid/ready channel interfaces for scheduler requests and responses.
// Depends on nothing; payload widths are fixed by the request/response format.
interface tts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [3:0] target_thread;

  modport source (output valid, output operation, output target_thread, input ready);
  modport sink (input valid, input operation, input target_thread, output ready);
endinterface

interface tts_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [3:0] new_thread;
  logic [3:0] running_thread;
  logic       switched;

  modport source (output valid, output status, output new_thread,
                  output running_thread, output switched, input ready);
  modport sink (input valid, input status, input new_thread,
                input running_thread, input switched, output ready);
endinterface

// ----- design/tts_table.sv -----
// Thread table memory: one read and one write port, registered read data.
// Depends on tts_pkg; per-entry valid bits give the reset contents.
module tts_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output tts_pkg::entry_t rd_data,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  tts_pkg::entry_t wr_data
);
  import tts_pkg::*;

  entry_t           mem [DEPTH];
  logic [DEPTH-1:0] written;
  entry_t           reset_entry;

  // Slot 0 comes out of reset running, every other slot dead.
  always_comb begin
    reset_entry.join_target = 4'd0;
    reset_entry.st          = (rd_addr == '0) ? SLOT_RUNNING : SLOT_DEAD;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Forward a same-cycle write to the read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && wr_addr == rd_addr) begin
        rd_data <= wr_data;
      end else if (written[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= reset_entry;
      end
    end
  end

endmodule

// ----- design/thread_table_round_robin_scheduler_unit.sv -----
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    operation[1:0], target_thread[3:0]
// rsp      out  valid/ready    status, new_thread[3:0], running_thread[3:0], switched
//
// One request at a time. Create, yield and join make one pass over the table,
// exit makes two (a wake-up pass, then a pick pass): each pass over the
// table reads one entry per cycle through the single read port of the table memory.
// Reset (rst, synchronous) leaves slot 0 running and all other slots dead.
// A finished response waits in the output register; a new request is taken
// while it waits, and a stalled rsp only holds the sequencer in its last step.
module thread_table_round_robin_scheduler_unit #(
  parameter int THREADS = 16
) (
  input logic clk,
  input logic rst,
  tts_req_if.sink   req,
  tts_rsp_if.source rsp
);
  import tts_pkg::*;

  localparam int SW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int NW = $clog2(THREADS + 1);
  localparam int CW = (SW > 4) ? SW : 4;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CRE  = 7'b0000010,
    S_EXIT = 7'b0000100,
    S_JT   = 7'b0001000,
    S_CUR  = 7'b0010000,
    S_PICK = 7'b0100000,
    S_DONE = 7'b1000000
  } fsm_t;

  fsm_t          fsm;
  logic [SW-1:0] running;
  logic [SW-1:0] before_q;
  op_t           op_q;
  logic [3:0]    tgt_q;
  logic          live_q;
  logic          fail_q;
  logic [SW-1:0] made_q;
  logic [SW-1:0] scan_addr;
  logic [NW-1:0] scan_cnt;
  logic          pend;
  logic [SW-1:0] pend_addr;
  logic          pend_last;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  entry_t        rd_data;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  entry_t        wr_data;

  logic          accept;
  logic          issue;
  logic          hit_cre;
  logic          hit_pick;
  logic          out_load;
  logic          tgt_in_range;
  logic [SW-1:0] tgt_addr;
  logic [SW-1:0] scan_addr_inc;
  logic [SW-1:0] pick_start;

  tts_table #(
    .DEPTH (THREADS),
    .AW    (SW)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign req.ready     = (fsm == S_IDLE);
  assign accept        = req.valid && req.ready;
  assign tgt_in_range  = (32'(req.target_thread) < THREADS);
  assign tgt_addr      = SW'(req.target_thread);
  assign scan_addr_inc = (scan_addr == SW'(THREADS - 1)) ? '0 : scan_addr + 1'b1;
  assign pick_start    = (running == SW'(THREADS - 1)) ? '0 : running + 1'b1;
  assign issue         = (fsm == S_CRE || fsm == S_EXIT || fsm == S_PICK) &&
                         (scan_cnt != NW'(THREADS));
  assign hit_cre       = (fsm == S_CRE) && pend && (rd_data.st == SLOT_DEAD);
  assign hit_pick      = (fsm == S_PICK) && pend && (rd_data.st == SLOT_RUNNABLE);
  assign out_load      = (fsm == S_DONE) && (!rsp.valid || rsp.ready);

  // Table read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_addr;
    if (issue) begin
      rd_en = 1'b1;
    end else if (accept && op_t'(req.operation) == OP_JOIN) begin
      rd_en   = 1'b1;
      rd_addr = tgt_addr;
    end else if (accept && op_t'(req.operation) == OP_YIELD) begin
      rd_en   = 1'b1;
      rd_addr = running;
    end else if (fsm == S_JT) begin
      rd_en   = 1'b1;
      rd_addr = running;
    end
  end

  // Table write port: modify the entry read in the previous cycle
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pend_addr;
    wr_data = rd_data;
    unique case (fsm)
      S_CRE: begin
        if (hit_cre) begin
          wr_en      = 1'b1;
          wr_data.st = SLOT_RUNNABLE;
        end
      end
      S_EXIT: begin
        if (pend) begin
          if (pend_addr == running) begin
            wr_en      = 1'b1;
            wr_data.st = SLOT_DEAD;
          end else if (rd_data.st == SLOT_BLOCKED &&
                       CW'(rd_data.join_target) == CW'(running)) begin
            wr_en      = 1'b1;
            wr_data.st = SLOT_RUNNABLE;
          end
        end
      end
      S_CUR: begin
        wr_addr = running;
        if (rd_data.st == SLOT_RUNNING) begin
          wr_en = 1'b1;
          if (op_q == OP_JOIN && live_q) begin
            wr_data.st          = SLOT_BLOCKED;
            wr_data.join_target = tgt_q;
          end else begin
            wr_data.st = SLOT_RUNNABLE;
          end
        end
      end
      S_PICK: begin
        if (hit_pick) begin
          wr_en      = 1'b1;
          wr_data.st = SLOT_RUNNING;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm     <= S_IDLE;
      running <= '0;
      pend    <= 1'b0;
    end else begin
      // advance the scan pipeline; a new scan is set up below
      if (issue) begin
        pend      <= 1'b1;
        pend_addr <= scan_addr;
        pend_last <= (scan_cnt == NW'(THREADS - 1));
        scan_addr <= scan_addr_inc;
        scan_cnt  <= scan_cnt + 1'b1;
      end else begin
        pend <= 1'b0;
      end

      unique case (fsm)
        S_IDLE: begin
          if (accept) begin
            op_q      <= op_t'(req.operation);
            tgt_q     <= req.target_thread;
            before_q  <= running;
            fail_q    <= 1'b0;
            made_q    <= '0;
            scan_addr <= '0;
            scan_cnt  <= '0;
            unique case (op_t'(req.operation))
              OP_CREATE: fsm <= S_CRE;
              OP_EXIT:   fsm <= S_EXIT;
              OP_JOIN: begin
                fsm    <= S_JT;
                live_q <= tgt_in_range;
              end
              OP_YIELD:  fsm <= S_CUR;
              default:   fsm <= S_IDLE;
            endcase
          end
        end
        S_CRE: begin
          if (hit_cre) begin
            made_q <= pend_addr;
            fsm    <= S_DONE;
          end else if (pend && pend_last) begin
            fail_q <= 1'b1;
            fsm    <= S_DONE;
          end
        end
        S_EXIT: begin
          if (pend && pend_last) begin
            scan_addr <= pick_start;
            scan_cnt  <= '0;
            fsm       <= S_PICK;
          end
        end
        S_JT: begin
          live_q <= live_q && (rd_data.st != SLOT_DEAD);
          fsm    <= S_CUR;
        end
        S_CUR: begin
          scan_addr <= pick_start;
          scan_cnt  <= '0;
          fsm       <= S_PICK;
        end
        S_PICK: begin
          if (hit_pick) begin
            running <= pend_addr;
            fsm     <= S_DONE;
          end else if (pend && pend_last) begin
            fail_q <= 1'b1;
            fsm    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            fsm <= S_IDLE;
          end
        end
        default: begin
          fsm <= S_IDLE;
        end
      endcase
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.status         <= fail_q;
      rsp.new_thread     <= 4'(made_q);
      rsp.running_thread <= 4'(running);
      rsp.switched       <= (running != before_q);
    end
  end

`ifndef NO_ASSERTIONS
  a_switch_means_success: assert property (@(posedge clk) disable iff (rst)
    out_load && (running != before_q) |-> !fail_q)
    else $error("switch reported on a failed request");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> fsm != S_IDLE)
    else $error("accepted request did not start the sequencer");

  a_write_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (fsm == S_CRE || fsm == S_EXIT || fsm == S_CUR || fsm == S_PICK))
    else $error("table write outside a working step");

  a_no_read_in_flight_idle: assert property (@(posedge clk) disable iff (rst)
    fsm == S_IDLE |-> !pend)
    else $error("scan read still in flight while idle");
`endif

endmodule
